// ----- hw/rtl/rsc_pkg.sv -----
// Shared types, constants and the microcode program of the RPN stack calculator.
// Used by rsc_sequencer, rsc_datapath and rpn_stack_calculator; depends on nothing.
`default_nettype none

package rsc_pkg;

    // Default number of stack entries
    localparam int DEF_STACK_DEPTH = 16;

    // Field widths
    localparam int OPC_W   = 3;
    localparam int DATA_W  = 32;
    localparam int STAT_W  = 2;
    localparam int DEPTH_W = 5;
    localparam int IN_TDATA_W  = 40;  // opcode + operand_value = 35 bits, padded to bytes
    localparam int OUT_TDATA_W = 40;  // status + top_value + stack_depth = 39 bits, padded

    // Divider runs one quotient bit per step, counting down to zero
    localparam int ITER_W = 5;
    localparam logic [ITER_W-1:0] DIV_ITER_LAST = ITER_W'(DATA_W - 1);

    typedef enum logic [OPC_W-1:0] {
        OPC_PUSH = 3'd0,
        OPC_ADD  = 3'd1,
        OPC_SUB  = 3'd2,
        OPC_MUL  = 3'd3,
        OPC_DIV  = 3'd4
    } t_opcode;

    typedef enum logic [STAT_W-1:0] {
        ST_OK   = 2'd0,
        ST_FEW  = 2'd1,
        ST_FULL = 2'd2,
        ST_DIVZ = 2'd3
    } t_status;

    // Datapath micro-operations
    typedef enum logic [3:0] {
        UOP_NOP,
        UOP_PUSH,
        UOP_READ,
        UOP_ADD,
        UOP_SUB,
        UOP_MUL,
        UOP_DIV_INIT,
        UOP_DIV_STEP,
        UOP_DIV_FIX,
        UOP_COMMIT,
        UOP_SET_FEW,
        UOP_SET_FULL,
        UOP_SET_DIVZ
    } t_uop;

    // Jump conditions: taken goes to target, otherwise fall through
    typedef enum logic [2:0] {
        CND_NEXT,
        CND_ALWAYS,
        CND_FEW,
        CND_FULL,
        CND_DIVZ,
        CND_LOOP
    } t_cond;

    localparam int UPC_W = 5;

    typedef struct packed {
        t_uop             uop;
        t_cond            cond;
        logic [UPC_W-1:0] target;
        logic             emit;
    } t_uword;

    // Sequencer to datapath
    typedef struct packed {
        logic accept;  // input transaction taken this cycle
        t_uop uop;     // operation to execute this cycle
        logic emit;    // load the result register this cycle
    } t_ctrl;

    // Datapath to sequencer
    typedef struct packed {
        logic few;       // fewer than two entries
        logic full;      // stack is full
        logic divz;      // second operand is zero
        logic loop_nz;   // divider iterations remain
        logic out_busy;  // result register holds an untaken result
    } t_flags;

    // Program labels
    localparam logic [UPC_W-1:0] L_PUSH   = 5'd0;
    localparam logic [UPC_W-1:0] L_ADD    = 5'd2;
    localparam logic [UPC_W-1:0] L_SUB    = 5'd5;
    localparam logic [UPC_W-1:0] L_MUL    = 5'd8;
    localparam logic [UPC_W-1:0] L_DIV    = 5'd11;
    localparam logic [UPC_W-1:0] L_DLOOP  = 5'd15;
    localparam logic [UPC_W-1:0] L_COMMIT = 5'd17;
    localparam logic [UPC_W-1:0] L_DONE   = 5'd18;
    localparam logic [UPC_W-1:0] L_FEW    = 5'd19;
    localparam logic [UPC_W-1:0] L_FULL   = 5'd20;
    localparam logic [UPC_W-1:0] L_DIVZ   = 5'd21;

    function automatic t_uword uw(t_uop uop, t_cond cond, logic [UPC_W-1:0] target,
                                  logic emit);
        t_uword w;
        w.uop    = uop;
        w.cond   = cond;
        w.target = target;
        w.emit   = emit;
        return w;
    endfunction

    // Microcode program
    function automatic t_uword ucode_rom(logic [UPC_W-1:0] pc);
        t_uword w;
        case (pc)
            // push
            5'd0:  w = uw(UOP_NOP,      CND_FULL,   L_FULL,   1'b0);
            5'd1:  w = uw(UOP_PUSH,     CND_ALWAYS, L_DONE,   1'b0);
            // add
            5'd2:  w = uw(UOP_NOP,      CND_FEW,    L_FEW,    1'b0);
            5'd3:  w = uw(UOP_READ,     CND_NEXT,   L_DONE,   1'b0);
            5'd4:  w = uw(UOP_ADD,      CND_ALWAYS, L_COMMIT, 1'b0);
            // subtract
            5'd5:  w = uw(UOP_NOP,      CND_FEW,    L_FEW,    1'b0);
            5'd6:  w = uw(UOP_READ,     CND_NEXT,   L_DONE,   1'b0);
            5'd7:  w = uw(UOP_SUB,      CND_ALWAYS, L_COMMIT, 1'b0);
            // multiply
            5'd8:  w = uw(UOP_NOP,      CND_FEW,    L_FEW,    1'b0);
            5'd9:  w = uw(UOP_READ,     CND_NEXT,   L_DONE,   1'b0);
            5'd10: w = uw(UOP_MUL,      CND_ALWAYS, L_COMMIT, 1'b0);
            // divide
            5'd11: w = uw(UOP_NOP,      CND_FEW,    L_FEW,    1'b0);
            5'd12: w = uw(UOP_READ,     CND_NEXT,   L_DONE,   1'b0);
            5'd13: w = uw(UOP_NOP,      CND_DIVZ,   L_DIVZ,   1'b0);
            5'd14: w = uw(UOP_DIV_INIT, CND_NEXT,   L_DONE,   1'b0);
            5'd15: w = uw(UOP_DIV_STEP, CND_LOOP,   L_DLOOP,  1'b0);
            5'd16: w = uw(UOP_DIV_FIX,  CND_NEXT,   L_DONE,   1'b0);
            // common tails
            5'd17: w = uw(UOP_COMMIT,   CND_NEXT,   L_DONE,   1'b0);
            5'd18: w = uw(UOP_NOP,      CND_NEXT,   L_DONE,   1'b1);
            5'd19: w = uw(UOP_SET_FEW,  CND_ALWAYS, L_DONE,   1'b0);
            5'd20: w = uw(UOP_SET_FULL, CND_ALWAYS, L_DONE,   1'b0);
            5'd21: w = uw(UOP_SET_DIVZ, CND_ALWAYS, L_DONE,   1'b0);
            default: w = uw(UOP_NOP,    CND_NEXT,   L_DONE,   1'b1);
        endcase
        return w;
    endfunction

    // Entry point of each opcode; unused opcodes report straight away
    function automatic logic [UPC_W-1:0] ucode_entry(logic [OPC_W-1:0] opc);
        logic [UPC_W-1:0] a;
        case (opc)
            OPC_PUSH: a = L_PUSH;
            OPC_ADD:  a = L_ADD;
            OPC_SUB:  a = L_SUB;
            OPC_MUL:  a = L_MUL;
            OPC_DIV:  a = L_DIV;
            default:  a = L_DONE;
        endcase
        return a;
    endfunction

    typedef enum logic {
        SEQ_IDLE,
        SEQ_RUN
    } t_seq_state;

endpackage

`default_nettype wire

// ----- hw/rtl/rsc_sequencer.sv -----
// Microcode sequencer: step counter, program ROM lookup and conditional jumps.
// Depends on rsc_pkg for the control word, the program and the flag structs.
`default_nettype none

module rsc_sequencer
    import rsc_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    input  wire logic [OPC_W-1:0]    i_opcode,
    input  wire t_flags              i_flags,
    output logic                     o_in_ready,
    output t_ctrl                    o_ctrl
);

    t_seq_state       r_state, n_state;
    logic [UPC_W-1:0] r_pc, n_pc;
    t_uword           word;
    logic             taken;
    logic             accept;

    // Hold state and step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SEQ_IDLE;
            r_pc    <= L_DONE;
        end else begin
            r_state <= n_state;
            r_pc    <= n_pc;
        end
    end

    // Evaluate the jump condition of the current word
    always_comb begin
        word = ucode_rom(r_pc);
        case (word.cond)
            CND_NEXT:   taken = 1'b0;
            CND_ALWAYS: taken = 1'b1;
            CND_FEW:    taken = i_flags.few;
            CND_FULL:   taken = i_flags.full;
            CND_DIVZ:   taken = i_flags.divz;
            CND_LOOP:   taken = i_flags.loop_nz;
            default:    taken = 1'b0;
        endcase
    end

    // Next step, controls to the datapath
    always_comb begin
        n_state     = r_state;
        n_pc        = r_pc;
        accept      = 1'b0;
        o_in_ready  = 1'b0;
        o_ctrl.uop  = UOP_NOP;
        o_ctrl.emit = 1'b0;
        case (r_state)
            SEQ_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    accept  = 1'b1;
                    n_pc    = ucode_entry(i_opcode);
                    n_state = SEQ_RUN;
                end
            end
            SEQ_RUN: begin
                o_ctrl.uop = word.uop;
                if (word.emit) begin
                    // stall until the result register is free
                    if (!i_flags.out_busy) begin
                        o_ctrl.emit = 1'b1;
                        n_state     = SEQ_IDLE;
                    end
                end else if (taken) begin
                    n_pc = word.target;
                end else begin
                    n_pc = r_pc + UPC_W'(1);
                end
            end
            default: n_state = SEQ_IDLE;
        endcase
        o_ctrl.accept = accept;
    end

endmodule

`default_nettype wire

// ----- hw/rtl/rsc_datapath.sv -----
// Datapath: stack memory with cached top entry, ALU, multiplier, shift-subtract
// divider and result register. Depends on rsc_pkg; driven by rsc_sequencer.
`default_nettype none

module rsc_datapath
    import rsc_pkg::*;
#(
    parameter int STACK_DEPTH = DEF_STACK_DEPTH
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire t_ctrl                    i_ctrl,
    input  wire logic signed [DATA_W-1:0] i_operand_value,
    input  wire logic                     i_out_ready,
    output t_flags                        o_flags,
    output logic                          o_out_valid,
    output logic [STAT_W-1:0]             o_status,
    output logic signed [DATA_W-1:0]      o_top_value,
    output logic [DEPTH_W-1:0]            o_stack_depth
);

    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    // Entries below the top; the top lives in r_top
    logic [DATA_W-1:0] mem [STACK_DEPTH];

    logic [CNT_W-1:0]  r_count, n_count;
    logic [DATA_W-1:0] r_top, n_top;
    logic [DATA_W-1:0] r_sec;
    logic [DATA_W-1:0] r_res, n_res;
    logic [DATA_W-1:0] r_opnd;
    logic [STAT_W-1:0] r_status, n_status;
    logic [DATA_W-1:0] r_den, n_den;
    logic [DATA_W-1:0] r_rem, n_rem;
    logic [DATA_W-1:0] r_quo, n_quo;
    logic              r_neg, n_neg;
    logic [ITER_W-1:0] r_iter, n_iter;
    logic              r_out_valid;

    logic [CNT_W-1:0]  cnt_m1, cnt_m2;
    logic              mem_we, mem_re;
    logic [DATA_W:0]   div_shift;
    logic              div_ge;

    assign cnt_m1 = r_count - CNT_W'(1);
    assign cnt_m2 = r_count - CNT_W'(2);
    assign mem_we = (i_ctrl.uop == UOP_PUSH) && (r_count != '0);
    assign mem_re = (i_ctrl.uop == UOP_READ);

    // Stack memory: one write and one registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[cnt_m1[ADDR_W-1:0]] <= r_top;
        end
        if (mem_re) begin
            r_sec <= mem[cnt_m2[ADDR_W-1:0]];
        end
    end

    // One restoring division step
    assign div_shift = {r_rem, r_quo[DATA_W-1]};
    assign div_ge    = div_shift >= {1'b0, r_den};

    // Execute the micro-operation
    always_comb begin
        n_count  = r_count;
        n_top    = r_top;
        n_res    = r_res;
        n_status = r_status;
        n_den    = r_den;
        n_rem    = r_rem;
        n_quo    = r_quo;
        n_neg    = r_neg;
        n_iter   = r_iter;
        if (i_ctrl.accept) begin
            n_status = ST_OK;
        end
        case (i_ctrl.uop)
            UOP_PUSH: begin
                n_top   = r_opnd;
                n_count = r_count + CNT_W'(1);
            end
            UOP_ADD: n_res = r_top + r_sec;
            UOP_SUB: n_res = r_top - r_sec;
            UOP_MUL: n_res = DATA_W'(r_top * r_sec);
            UOP_DIV_INIT: begin
                n_quo  = r_top[DATA_W-1] ? (DATA_W'(0) - r_top) : r_top;
                n_den  = r_sec[DATA_W-1] ? (DATA_W'(0) - r_sec) : r_sec;
                n_rem  = '0;
                n_neg  = r_top[DATA_W-1] ^ r_sec[DATA_W-1];
                n_iter = DIV_ITER_LAST;
            end
            UOP_DIV_STEP: begin
                n_rem  = div_ge ? DATA_W'(div_shift - {1'b0, r_den}) : div_shift[DATA_W-1:0];
                n_quo  = {r_quo[DATA_W-2:0], div_ge};
                n_iter = r_iter - ITER_W'(1);
            end
            UOP_DIV_FIX: n_res = r_neg ? (DATA_W'(0) - r_quo) : r_quo;
            UOP_COMMIT: begin
                n_top   = r_res;
                n_count = cnt_m1;
            end
            UOP_SET_FEW:  n_status = ST_FEW;
            UOP_SET_FULL: n_status = ST_FULL;
            UOP_SET_DIVZ: n_status = ST_DIVZ;
            default: ;
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (i_ctrl.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_top    <= n_top;
        r_res    <= n_res;
        r_status <= n_status;
        r_den    <= n_den;
        r_rem    <= n_rem;
        r_quo    <= n_quo;
        r_neg    <= n_neg;
        r_iter   <= n_iter;
        if (i_ctrl.accept) begin
            r_opnd <= i_operand_value;
        end
        if (i_ctrl.emit) begin
            o_status      <= r_status;
            o_top_value   <= (r_count != '0) ? r_top : '0;
            o_stack_depth <= DEPTH_W'(r_count);
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_flags.few      = r_count < CNT_W'(2);
    assign o_flags.full     = r_count == CNT_W'(STACK_DEPTH);
    assign o_flags.divz     = r_sec == '0;
    assign o_flags.loop_nz  = r_iter != '0;
    assign o_flags.out_busy = r_out_valid && !i_out_ready;

endmodule

`default_nettype wire

// ----- hw/rtl/rpn_stack_calculator.sv -----
// Top level of the RPN stack calculator: stream ports, sequencer and datapath.
// Depends on rsc_pkg, rsc_sequencer and rsc_datapath.
//
// Usage:
//   Input stream carries one decoded token per transaction: push a signed
//   value, or add, subtract, multiply or divide the two top entries (top op
//   second). Every token yields exactly one result transaction with status,
//   the new top value (zero when empty) and the new depth.
//   Tokens run one at a time through a microcode program; s_axis_tready is
//   high while the sequencer is idle. A divide runs 32 steps of the one-bit
//   divider loop before its result is loaded.
//   The next token is taken the cycle after the result is loaded, so tokens
//   never overlap.
//   A result waits in the output register while m_axis_tready is low; the
//   next token is still accepted and runs up to its own result, where the
//   program stalls until the register is free.
//   Reset (synchronous, active low) empties the stack and drops any pending
//   result; stack contents need no clearing.
`default_nettype none

module rpn_stack_calculator
    import rsc_pkg::*;
#(
    parameter int STACK_DEPTH = DEF_STACK_DEPTH
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,   // opcode[2:0], operand_value[34:3]
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata    // status[1:0], top_value[33:2],
                                                        // stack_depth[38:34]
);

    t_ctrl                    ctrl;
    t_flags                   flags;
    logic [OPC_W-1:0]         opcode;
    logic signed [DATA_W-1:0] operand_value;
    logic [STAT_W-1:0]        status;
    logic signed [DATA_W-1:0] top_value;
    logic [DEPTH_W-1:0]       stack_depth;

    // Unpack the input token
    assign opcode        = s_axis_tdata[OPC_W-1:0];
    assign operand_value = s_axis_tdata[OPC_W+DATA_W-1:OPC_W];

    rsc_sequencer u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_opcode   (opcode),
        .i_flags    (flags),
        .o_in_ready (s_axis_tready),
        .o_ctrl     (ctrl)
    );

    rsc_datapath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctrl          (ctrl),
        .i_operand_value (operand_value),
        .i_out_ready     (m_axis_tready),
        .o_flags         (flags),
        .o_out_valid     (m_axis_tvalid),
        .o_status        (status),
        .o_top_value     (top_value),
        .o_stack_depth   (stack_depth)
    );

    // Pack the result, zero pad to whole bytes
    assign m_axis_tdata = {1'b0, stack_depth, top_value, status};

endmodule

`default_nettype wire

// ----- dv/tb_rpn_stack_calculator.sv -----
// Self-checking testbench for rpn_stack_calculator: drives decoded tokens, predicts each
// result from its own stack model and compares status, top value and depth.
// Depends on rsc_pkg and rpn_stack_calculator.
module tb_rpn_stack_calculator
    import rsc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STACK_ENTRIES = DEF_STACK_DEPTH;
    localparam int PHASE_TOKENS  = 200;
    localparam int BURST_LEN     = 20;
    localparam int DRAIN_CYCLES  = 60;
    localparam int CYCLE_LIMIT   = 600000;

    // Opcodes the block leaves unused
    localparam logic [OPC_W-1:0] OPC_SPARE_FIRST = 3'd5;
    localparam logic [OPC_W-1:0] OPC_SPARE_LAST  = 3'd7;

    typedef struct {
        logic [OPC_W-1:0]  opcode;
        logic [DATA_W-1:0] operand;
        int unsigned       gap_pct;
        int unsigned       stall_pct;
    } t_token;

    typedef struct {
        t_status            status;
        logic [DATA_W-1:0]  top;
        logic [DEPTH_W-1:0] depth;
    } t_calc_result;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    t_token       tokens_to_send[$];
    t_token       on_bus;
    t_calc_result predicted_results[$];
    int unsigned  recv_stall_pct = 0;
    int unsigned  fail_count = 0;
    int unsigned  cycle_count = 0;

    // Predictor state: stack contents and number of valid entries
    logic [DATA_W-1:0] calc_stack [STACK_ENTRIES];
    int unsigned       calc_count = 0;

    rpn_stack_calculator #(
        .STACK_DEPTH(STACK_ENTRIES)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // opcode[2:0], operand_value[34:3]
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)    // status[1:0], top_value[33:2], stack_depth[38:34]
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Signed divide, truncating toward zero; the most negative value over -1 wraps
    function automatic logic [DATA_W-1:0] quot_trunc(logic [DATA_W-1:0] num,
                                                      logic [DATA_W-1:0] den);
        logic [DATA_W-1:0] un, ud, q;
        un = num[DATA_W-1] ? -num : num;
        ud = den[DATA_W-1] ? -den : den;
        q  = un / ud;
        return (num[DATA_W-1] ^ den[DATA_W-1]) ? -q : q;
    endfunction

    // Apply one token to the predictor stack and return the result it reports
    function automatic t_calc_result calc_eval(logic [OPC_W-1:0] opc, logic [DATA_W-1:0] val);
        t_calc_result      r;
        logic [DATA_W-1:0] t, s, v;
        r.status = ST_OK;
        v = '0;
        if (opc == OPC_PUSH) begin
            if (calc_count >= STACK_ENTRIES) begin
                r.status = ST_FULL;
            end else begin
                calc_stack[calc_count] = val;
                calc_count++;
            end
        end else if (opc <= OPC_DIV) begin
            if (calc_count < 2) begin
                r.status = ST_FEW;
            end else begin
                t = calc_stack[calc_count - 1];
                s = calc_stack[calc_count - 2];
                case (opc)
                    OPC_ADD: v = t + s;
                    OPC_SUB: v = t - s;
                    OPC_MUL: v = t * s;
                    default: begin
                        if (s == '0) r.status = ST_DIVZ;
                        else v = quot_trunc(t, s);
                    end
                endcase
                if (r.status == ST_OK) begin
                    calc_count--;
                    calc_stack[calc_count - 1] = v;
                end
            end
        end
        r.top   = (calc_count > 0) ? calc_stack[calc_count - 1] : '0;
        r.depth = DEPTH_W'(calc_count);
        return r;
    endfunction

    // Operand mix: extremes, small values (zeros for divide checks), mid-size and full range
    function automatic logic [DATA_W-1:0] pick_operand();
        logic [15:0]       half;
        logic [DATA_W-1:0] v;
        half = 16'($urandom());
        case ($urandom_range(9))
            0: begin
                case ($urandom_range(4))
                    0: v = 32'h8000_0000;
                    1: v = 32'h7FFF_FFFF;
                    2: v = 32'hFFFF_FFFF;
                    3: v = 32'h0000_0001;
                    default: v = '0;
                endcase
            end
            1, 2, 3, 4: v = DATA_W'($urandom_range(16)) - 32'd8;
            5, 6: v = {{16{half[15]}}, half};
            default: v = $urandom();
        endcase
        return v;
    endfunction

    function automatic void add_token(logic [OPC_W-1:0] opc, logic [DATA_W-1:0] val,
                                      int unsigned gap, int unsigned stall);
        t_token tk;
        tk.opcode    = opc;
        tk.operand   = val;
        tk.gap_pct   = gap;
        tk.stall_pct = stall;
        tokens_to_send.push_back(tk);
    endfunction

    // Present tokens; predict each one as its transaction completes
    always @(posedge i_clk) begin : token_driver
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                predicted_results.push_back(calc_eval(on_bus.opcode, on_bus.operand));
                recv_stall_pct <= on_bus.stall_pct;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (tokens_to_send.size() != 0 &&
                    $urandom_range(99) >= tokens_to_send[0].gap_pct) begin
                    on_bus = tokens_to_send.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {{(IN_TDATA_W - OPC_W - DATA_W){1'b0}},
                                      on_bus.operand, on_bus.opcode};
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Compare each result transaction with the oldest prediction; stall at random
    always @(posedge i_clk) begin : result_monitor
        t_calc_result       want;
        t_status            got_status;
        logic [DATA_W-1:0]  got_top;
        logic [DEPTH_W-1:0] got_depth;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got_status = t_status'(m_axis_tdata[STAT_W-1:0]);
                got_top    = m_axis_tdata[STAT_W +: DATA_W];
                got_depth  = m_axis_tdata[STAT_W + DATA_W +: DEPTH_W];
                if (predicted_results.size() == 0) begin
                    $error("unexpected result transaction: tdata %h", m_axis_tdata);
                    fail_count++;
                end else begin
                    want = predicted_results.pop_front();
                    if (got_status != want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, got_status);
                        fail_count++;
                    end
                    if (got_top != want.top) begin
                        $error("top_value: expected %0d, actual %0d",
                               $signed(want.top), $signed(got_top));
                        fail_count++;
                    end
                    if (got_depth != want.depth) begin
                        $error("stack_depth: expected %0d, actual %0d", want.depth, got_depth);
                        fail_count++;
                    end
                end
            end
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Stop a hung run
    always @(posedge i_clk) begin : watchdog
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb_rpn_stack_calculator NOT OK");
            $finish;
        end
    end

    initial begin : stimulus
        int unsigned gap_by_phase [4];
        int unsigned stall_by_phase [4];
        int unsigned push_mix [4];
        int unsigned push_pct;
        int unsigned roll;
        logic [OPC_W-1:0] opc;

        gap_by_phase   = '{0, 53, 0, 19};
        stall_by_phase = '{0, 0, 53, 19};
        push_mix       = '{25, 45, 60, 85};
        push_pct       = 50;

        // Directed: operations on an empty stack, an unused opcode, too few operands,
        // divide by zero, wrapping add, divide overflow, wrapping multiply, full stack
        add_token(OPC_ADD, 32'h0000_0000, 0, 0);
        add_token(OPC_DIV, 32'hFFFF_FFFF, 0, 0);
        add_token(OPC_SPARE_FIRST, 32'h1234_5678, 0, 0);
        add_token(OPC_PUSH, 32'h7FFF_FFFF, 0, 0);
        add_token(OPC_SUB, 32'h0000_0000, 0, 0);
        add_token(OPC_PUSH, 32'h0000_0000, 0, 0);
        add_token(OPC_PUSH, 32'h0000_0005, 0, 0);
        add_token(OPC_DIV, 32'h0000_0000, 0, 0);
        add_token(OPC_ADD, 32'h0000_0000, 0, 0);
        add_token(OPC_ADD, 32'h0000_0000, 0, 0);
        add_token(OPC_PUSH, 32'hFFFF_FFFF, 0, 0);
        add_token(OPC_PUSH, 32'h8000_0000, 0, 0);
        add_token(OPC_DIV, 32'h0000_0000, 0, 0);
        add_token(OPC_MUL, 32'hFFFF_FFFF, 0, 0);
        repeat (STACK_ENTRIES) add_token(OPC_PUSH, pick_operand(), 0, 0);
        add_token(OPC_SUB, 32'h0000_0000, 0, 0);

        // Random: bursts with a varying push share so depth sweeps from empty to full
        for (int ph = 0; ph < 4; ph++) begin
            for (int n = 0; n < PHASE_TOKENS; n++) begin
                if (n % BURST_LEN == 0) push_pct = push_mix[$urandom_range(3)];
                roll = $urandom_range(99);
                if (roll < push_pct) opc = OPC_PUSH;
                else if (roll < 97) opc = OPC_W'($urandom_range(OPC_ADD, OPC_DIV));
                else opc = OPC_W'($urandom_range(OPC_SPARE_FIRST, OPC_SPARE_LAST));
                add_token(opc, pick_operand(), gap_by_phase[ph], stall_by_phase[ph]);
            end
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for every token to go out, then for every result to come back
        do @(negedge i_clk); while (tokens_to_send.size() != 0 || s_axis_tvalid);
        while (predicted_results.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (fail_count == 0) begin
            $display("tb_rpn_stack_calculator OK");
        end else begin
            $display("tb_rpn_stack_calculator NOT OK");
        end
        $finish;
    end

endmodule
